// ===== src/lcd_seq_pkg.sv =====
// shared types and constants for the lcd nibble command sequencer
`timescale 1ns / 1ps

package lcd_seq_pkg;

	// default command queue depth
	localparam int QUEUE_DEPTH = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RS_PIN_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EN_PIN_MASK = 1'd1;
	localparam logic [2:0] RS_PIN_MASK_RST = 3'd1;
	localparam logic [2:0] EN_PIN_MASK_RST = 3'd4;

	// expander writes per command kind
	localparam logic [2:0] WRITES_NIBBLE = 3'd3;
	localparam logic [2:0] WRITES_BYTE   = 3'd6;
	localparam logic [2:0] ACKS_MAX      = 3'd7;

	// pushed command kinds
	localparam logic [1:0] KIND_DELAY  = 2'd0;
	localparam logic [1:0] KIND_NIBBLE = 2'd1;
	localparam logic [1:0] KIND_BYTE   = 2'd2;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_TICK = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EMIT_NONE   = 2'd0,
		EMIT_NIBBLE = 2'd1,
		EMIT_BYTE   = 2'd2
	} emit_t;

	// one queued command
	typedef struct packed {
		logic [1:0]  kind;
		logic        is_data;
		logic [7:0]  value;
		logic [15:0] delay;
	} entry_t;

	// one accepted input beat
	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  kind;
		logic [7:0]  value;
		logic        is_data;
		logic [15:0] delay;
	} in_beat_t;

	// queue control from the core
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   clear;
		entry_t wdata;
	} q_ctrl_t;

	// results of one step, handed to the output stage
	typedef struct packed {
		emit_t      emit;
		logic [3:0] nib_a;
		logic [3:0] nib_b;
		logic       is_data;
		logic       idle;
		logic       dropped;
	} grp_t;

	// core status for checks
	typedef struct packed {
		phase_t     phase;
		logic [2:0] acks;
		logic [1:0] kind;
		logic       busy;
	} core_stat_t;

endpackage

// ===== src/lcd_seq_if.sv =====
// channel interfaces for command input and expander byte output
`timescale 1ns / 1ps

interface lcd_seq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [1:0]  cmd_kind;
	logic [7:0]  value;
	logic        is_data;
	logic [15:0] post_delay_ms;

	modport source (output valid, cmd, cmd_kind, value, is_data, post_delay_ms, input ready);
	modport sink (input valid, cmd, cmd_kind, value, is_data, post_delay_ms, output ready);
endinterface

interface lcd_seq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] expander_byte;
	logic       byte_valid;
	logic       last;
	logic       idle;
	logic       push_dropped;

	modport source (output valid, expander_byte, byte_valid, last, idle, push_dropped,
		input ready);
	modport sink (input valid, expander_byte, byte_valid, last, idle, push_dropped,
		output ready);
endinterface

// ===== src/lcd_nibble_command_sequencer.sv =====
// top level of the lcd nibble command sequencer
//
//  channel   dir  handshake              payload
//  cmd_ch    in   valid / ready          cmd, cmd_kind, value, is_data, post_delay_ms
//  res_ch    out  valid / ready          expander_byte, byte_valid, last, idle, push_dropped
//  cfg       in   cfg_we                 cfg_index, cfg_wdata (no read-back)
//
// an event is handled in the core, followed by a separate step for every queued command
// that it starts; a zero delay or unused kind entry takes one such step each
// results leave one beat a cycle from a group register while res_ch is ready,
// one to six beats per event, six when a command start sends a byte
// the core holds an event at its end while the previous group is still going out
// reset clears pointers, phase and counters and sets the pin masks to 1 and 4;
// queue entries are never cleared since only written entries are read
`timescale 1ns / 1ps

module lcd_nibble_command_sequencer #(
	parameter int QUEUE_DEPTH = lcd_seq_pkg::QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lcd_seq_in_if.sink                        cmd_ch,
	lcd_seq_out_if.source                     res_ch,
	input  logic                              cfg_we,
	input  logic [lcd_seq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [2:0]                        cfg_wdata
);

	lcd_seq_pkg::q_ctrl_t    q_ctrl;
	lcd_seq_pkg::entry_t     q_head;
	logic [CW-1:0]           q_count;
	logic                    grp_free;
	logic                    grp_load;
	lcd_seq_pkg::grp_t       grp;
	lcd_seq_pkg::core_stat_t stat;
	logic [2:0]              rs_mask_q;
	logic [2:0]              en_mask_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_mask_q <= lcd_seq_pkg::RS_PIN_MASK_RST;
			en_mask_q <= lcd_seq_pkg::EN_PIN_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lcd_seq_pkg::CFG_RS_PIN_MASK: rs_mask_q <= cfg_wdata;
				lcd_seq_pkg::CFG_EN_PIN_MASK: en_mask_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lcd_seq_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (q_ctrl),
		.head  (q_head),
		.count (q_count)
	);

	lcd_seq_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.q_head  (q_head),
		.q_count (q_count),
		.q_ctrl  (q_ctrl),
		.grp_free(grp_free),
		.grp_load(grp_load),
		.grp     (grp),
		.stat    (stat)
	);

	lcd_seq_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (grp_load),
		.grp_in (grp),
		.free   (grp_free),
		.rs_mask(rs_mask_q),
		.en_mask(en_mask_q),
		.res_ch (res_ch)
	);

	// queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// a command start is only attempted with something in the queue
	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (q_count != '0))
		else $error("command start with empty queue");

	// while sending, acknowledges seen stay below the writes of the active command
	a_send_acks: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.phase == lcd_seq_pkg::PH_SEND) |->
		((stat.kind == lcd_seq_pkg::KIND_NIBBLE && stat.acks < lcd_seq_pkg::WRITES_NIBBLE) ||
		(stat.kind == lcd_seq_pkg::KIND_BYTE && stat.acks < lcd_seq_pkg::WRITES_BYTE)))
		else $error("send phase with bad kind or acknowledge count");

	// a group is never loaded over one that still has beats to go
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		grp_load |-> grp_free)
		else $error("result group overwritten");

endmodule

// ===== src/lcd_seq_queue.sv =====
// command queue: circular memory with head read register and write forwarding
`timescale 1ns / 1ps

module lcd_seq_queue #(
	parameter int QUEUE_DEPTH = lcd_seq_pkg::QUEUE_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcd_seq_pkg::q_ctrl_t ctrl,
	output lcd_seq_pkg::entry_t  head,
	output logic [CW-1:0]        count
);

	lcd_seq_pkg::entry_t mem [QUEUE_DEPTH];
	lcd_seq_pkg::entry_t rd_q;
	lcd_seq_pkg::entry_t fwd_data_q;
	logic                fwd_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [AW-1:0]       head_nxt;
	logic [AW-1:0]       tail_nxt;
	logic [CW-1:0]       count_q;

	// pointer updates with wrap at the queue depth
	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		if (ctrl.clear) begin
			head_nxt = '0;
			tail_nxt = '0;
		end else begin
			if (ctrl.pop) begin
				head_nxt = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (ctrl.push) begin
				tail_nxt = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fwd_q   <= 1'b0;
		end else begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CW'(1);
			end
			fwd_q <= ctrl.push && (tail_q == head_nxt);
		end
	end

	// storage and registered read of the next head entry
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= ctrl.wdata;
		end
		rd_q       <= mem[head_nxt];
		fwd_data_q <= ctrl.wdata;
	end

	assign head  = fwd_q ? fwd_data_q : rd_q;
	assign count = count_q;

endmodule

// ===== src/lcd_seq_core.sv =====
// sequencer core: input register, event handling and command start
`timescale 1ns / 1ps

module lcd_seq_core #(
	parameter int QUEUE_DEPTH = lcd_seq_pkg::QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	lcd_seq_in_if.sink              cmd_ch,
	input  lcd_seq_pkg::entry_t     q_head,
	input  logic [CW-1:0]           q_count,
	output lcd_seq_pkg::q_ctrl_t    q_ctrl,
	input  logic                    grp_free,
	output logic                    grp_load,
	output lcd_seq_pkg::grp_t       grp,
	output lcd_seq_pkg::core_stat_t stat
);

	logic                  valid_s1;
	lcd_seq_pkg::in_beat_t in_s1;

	lcd_seq_pkg::phase_t phase_q;
	lcd_seq_pkg::entry_t active_q;
	logic [2:0]          acks_q;
	logic [15:0]         delay_q;
	logic                busy_q;
	logic                dropped_q;

	// state after the event of the input register
	lcd_seq_pkg::phase_t phase_a;
	lcd_seq_pkg::entry_t active_a;
	logic [2:0]          acks_a;
	logic [2:0]          acks_inc;
	logic [2:0]          need;
	logic [15:0]         delay_a;
	logic [15:0]         delay_dec;
	logic [CW-1:0]       count_a;
	logic                push_a;
	logic                drop_a;
	logic                clear_a;
	logic                start_a;

	// state after starting the head command
	lcd_seq_pkg::phase_t phase_p;
	logic [15:0]         delay_p;
	logic [CW-1:0]       count_p;
	lcd_seq_pkg::emit_t  emit_p;
	logic                cont_p;

	logic take_s1;
	logic step_p;

	// next state of the event and of one command start
	always_comb begin
		phase_a   = phase_q;
		active_a  = active_q;
		acks_a    = acks_q;
		delay_a   = delay_q;
		count_a   = q_count;
		push_a    = 1'b0;
		drop_a    = 1'b0;
		clear_a   = 1'b0;
		acks_inc  = (acks_q != lcd_seq_pkg::ACKS_MAX) ? acks_q + 3'd1 : acks_q;
		need      = (active_q.kind == lcd_seq_pkg::KIND_NIBBLE) ?
			lcd_seq_pkg::WRITES_NIBBLE : lcd_seq_pkg::WRITES_BYTE;
		delay_dec = (delay_q != 16'd0) ? delay_q - 16'd1 : 16'd0;
		case (in_s1.cmd)
			lcd_seq_pkg::CMD_PUSH: begin
				if (q_count >= CW'(QUEUE_DEPTH)) begin
					drop_a = 1'b1;
				end else begin
					push_a  = 1'b1;
					count_a = q_count + CW'(1);
				end
			end
			lcd_seq_pkg::CMD_ACK: begin
				if (phase_q == lcd_seq_pkg::PH_SEND) begin
					acks_a = acks_inc;
					if (acks_inc >= need) begin
						if (active_q.delay != 16'd0) begin
							phase_a = lcd_seq_pkg::PH_WAIT;
							delay_a = active_q.delay;
						end else begin
							phase_a = lcd_seq_pkg::PH_IDLE;
						end
					end
				end
			end
			lcd_seq_pkg::CMD_TICK: begin
				if (phase_q == lcd_seq_pkg::PH_WAIT) begin
					delay_a = delay_dec;
					if (delay_dec == 16'd0) begin
						phase_a = lcd_seq_pkg::PH_IDLE;
					end
				end
			end
			lcd_seq_pkg::CMD_STOP: begin
				clear_a  = 1'b1;
				count_a  = '0;
				phase_a  = lcd_seq_pkg::PH_IDLE;
				active_a = '0;
				acks_a   = 3'd0;
				delay_a  = 16'd0;
			end
			default: begin
			end
		endcase
		start_a = (in_s1.cmd != lcd_seq_pkg::CMD_STOP) &&
			(phase_a == lcd_seq_pkg::PH_IDLE) && (count_a != '0);

		// one command start from the queue head
		phase_p = phase_q;
		delay_p = delay_q;
		count_p = q_count - CW'(1);
		emit_p  = lcd_seq_pkg::EMIT_NONE;
		case (q_head.kind)
			lcd_seq_pkg::KIND_DELAY: begin
				if (q_head.delay != 16'd0) begin
					phase_p = lcd_seq_pkg::PH_WAIT;
					delay_p = q_head.delay;
				end
			end
			lcd_seq_pkg::KIND_NIBBLE: begin
				phase_p = lcd_seq_pkg::PH_SEND;
				emit_p  = lcd_seq_pkg::EMIT_NIBBLE;
			end
			lcd_seq_pkg::KIND_BYTE: begin
				phase_p = lcd_seq_pkg::PH_SEND;
				emit_p  = lcd_seq_pkg::EMIT_BYTE;
			end
			default: begin
			end
		endcase
		cont_p = (phase_p == lcd_seq_pkg::PH_IDLE) && (count_p != '0);
	end

	// a step completes only when its results have somewhere to go
	assign step_p  = busy_q && (cont_p || grp_free);
	assign take_s1 = valid_s1 && !busy_q && (start_a || grp_free);

	// queue control, result group and input handshake
	always_comb begin
		q_ctrl       = '0;
		q_ctrl.wdata = '{kind: in_s1.kind, is_data: in_s1.is_data, value: in_s1.value,
			delay: in_s1.delay};
		grp_load     = 1'b0;
		grp          = '0;
		if (busy_q) begin
			q_ctrl.pop  = step_p;
			grp_load    = step_p && !cont_p;
			grp.emit    = emit_p;
			grp.nib_a   = (q_head.kind == lcd_seq_pkg::KIND_BYTE) ?
				q_head.value[7:4] : q_head.value[3:0];
			grp.nib_b   = q_head.value[3:0];
			grp.is_data = q_head.is_data;
			grp.idle    = (phase_p == lcd_seq_pkg::PH_IDLE) && (count_p == '0);
			grp.dropped = dropped_q;
		end else begin
			q_ctrl.push  = take_s1 && push_a;
			q_ctrl.clear = take_s1 && clear_a;
			grp_load     = take_s1 && !start_a;
			grp.emit     = lcd_seq_pkg::EMIT_NONE;
			grp.idle     = (phase_a == lcd_seq_pkg::PH_IDLE) && (count_a == '0);
			grp.dropped  = drop_a;
		end
	end

	assign cmd_ch.ready = !valid_s1 || take_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			in_s1 <= '{cmd: lcd_seq_pkg::cmd_t'(cmd_ch.cmd), kind: cmd_ch.cmd_kind,
				value: cmd_ch.value, is_data: cmd_ch.is_data, delay: cmd_ch.post_delay_ms};
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lcd_seq_pkg::PH_IDLE;
			active_q  <= '0;
			acks_q    <= 3'd0;
			delay_q   <= 16'd0;
			busy_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else if (busy_q) begin
			if (step_p) begin
				phase_q  <= phase_p;
				active_q <= q_head;
				acks_q   <= 3'd0;
				delay_q  <= delay_p;
				busy_q   <= cont_p;
			end
		end else if (take_s1) begin
			phase_q   <= phase_a;
			active_q  <= active_a;
			acks_q    <= acks_a;
			delay_q   <= delay_a;
			busy_q    <= start_a;
			dropped_q <= drop_a;
		end
	end

	assign stat = '{phase: phase_q, acks: acks_q, kind: active_q.kind, busy: busy_q};

endmodule

// ===== src/lcd_seq_out.sv =====
// result stage: holds one step's results and sends them one beat a cycle while the receiver is ready
`timescale 1ns / 1ps

module lcd_seq_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lcd_seq_pkg::grp_t grp_in,
	output logic              free,
	input  logic [2:0]        rs_mask,
	input  logic [2:0]        en_mask,
	lcd_seq_out_if.source     res_ch
);

	lcd_seq_pkg::grp_t grp_q;
	logic              grp_valid_q;
	logic [2:0]        beat_q;
	logic              last_beat;
	logic              second;
	logic [2:0]        pos;
	logic [3:0]        nib;
	logic [7:0]        base;

	// last beat of the group
	always_comb begin
		case (grp_q.emit)
			lcd_seq_pkg::EMIT_NONE:   last_beat = 1'b1;
			lcd_seq_pkg::EMIT_NIBBLE: last_beat = beat_q == lcd_seq_pkg::WRITES_NIBBLE - 3'd1;
			lcd_seq_pkg::EMIT_BYTE:   last_beat = beat_q == lcd_seq_pkg::WRITES_BYTE - 3'd1;
			default:                  last_beat = 1'b1;
		endcase
	end

	// byte of the current beat: base, base with strobe, base
	always_comb begin
		second = beat_q >= lcd_seq_pkg::WRITES_NIBBLE;
		pos    = second ? beat_q - lcd_seq_pkg::WRITES_NIBBLE : beat_q;
		nib    = second ? grp_q.nib_b : grp_q.nib_a;
		base   = {1'b0, nib, 3'b000} | (grp_q.is_data ? {5'b0, rs_mask} : 8'h00);
	end

	assign res_ch.valid         = grp_valid_q;
	assign res_ch.byte_valid    = grp_q.emit != lcd_seq_pkg::EMIT_NONE;
	assign res_ch.expander_byte = !res_ch.byte_valid ? 8'h00 :
		(pos == 3'd1) ? (base | {5'b0, en_mask}) : base;
	assign res_ch.last          = last_beat;
	assign res_ch.idle          = grp_q.idle;
	assign res_ch.push_dropped  = grp_q.dropped;

	assign free = !grp_valid_q || (res_ch.ready && last_beat);

	// group register and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			beat_q      <= 3'd0;
		end else if (load) begin
			grp_valid_q <= 1'b1;
			beat_q      <= 3'd0;
		end else if (grp_valid_q && res_ch.ready) begin
			if (last_beat) begin
				grp_valid_q <= 1'b0;
				beat_q      <= 3'd0;
			end else begin
				beat_q <= beat_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_in;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the lcd nibble command sequencer with a predicting scoreboard
`timescale 1ns / 1ps

// one expander write as seen on the result channel
typedef struct packed {
	logic [7:0] pins;
	logic       written;
	logic       last;
	logic       idle;
	logic       dropped;
} pin_write_t;

// predicts expander writes per accepted event and checks them in order
class lcd_seq_board;
	lcd_seq_pkg::entry_t fifo [lcd_seq_pkg::QUEUE_DEPTH];
	int unsigned         head;
	int unsigned         tail;
	int unsigned         count;
	lcd_seq_pkg::phase_t ph;
	lcd_seq_pkg::entry_t cur;
	int unsigned         acks;
	int unsigned         delay_left;
	logic [2:0]          rs_mask;
	logic [2:0]          en_mask;
	logic [7:0]          strobe_seq [$];
	pin_write_t          pending_writes [$];
	int                  errors;

	function new();
		head = 0;
		tail = 0;
		count = 0;
		ph = lcd_seq_pkg::PH_IDLE;
		cur = '0;
		acks = 0;
		delay_left = 0;
		rs_mask = lcd_seq_pkg::RS_PIN_MASK_RST;
		en_mask = lcd_seq_pkg::EN_PIN_MASK_RST;
		errors = 0;
	endfunction

	// set-up, strobe and hold writes for one nibble
	function void add_nibble(logic [3:0] nib, logic is_data);
		logic [7:0] base;
		base = {1'b0, nib, 3'b000} | {5'b0, (is_data ? rs_mask : 3'b000)};
		strobe_seq.push_back(base);
		strobe_seq.push_back(base | {5'b0, en_mask});
		strobe_seq.push_back(base);
	endfunction

	// pull queued commands until one keeps the sequencer busy or the queue is empty
	function void launch_queued();
		while (ph == lcd_seq_pkg::PH_IDLE && count > 0) begin
			cur = fifo[head];
			head = (head + 1) % lcd_seq_pkg::QUEUE_DEPTH;
			count--;
			acks = 0;
			case (cur.kind)
				lcd_seq_pkg::KIND_DELAY: begin
					if (cur.delay != 0) begin
						ph = lcd_seq_pkg::PH_WAIT;
						delay_left = 32'(cur.delay);
					end
				end
				lcd_seq_pkg::KIND_NIBBLE: begin
					ph = lcd_seq_pkg::PH_SEND;
					add_nibble(cur.value[3:0], cur.is_data);
				end
				lcd_seq_pkg::KIND_BYTE: begin
					ph = lcd_seq_pkg::PH_SEND;
					add_nibble(cur.value[7:4], cur.is_data);
					add_nibble(cur.value[3:0], cur.is_data);
				end
				default: ;
			endcase
		end
	endfunction

	// advance the model by one accepted event and queue its writes
	function void note_event(lcd_seq_pkg::in_beat_t ev);
		logic        dropped;
		logic        idle_now;
		int unsigned need;
		dropped = 1'b0;
		strobe_seq.delete();
		case (ev.cmd)
			lcd_seq_pkg::CMD_PUSH: begin
				if (count >= lcd_seq_pkg::QUEUE_DEPTH) begin
					dropped = 1'b1;
				end else begin
					fifo[tail] = '{kind: ev.kind, is_data: ev.is_data, value: ev.value,
						delay: ev.delay};
					tail = (tail + 1) % lcd_seq_pkg::QUEUE_DEPTH;
					count++;
				end
			end
			lcd_seq_pkg::CMD_ACK: begin
				if (ph == lcd_seq_pkg::PH_SEND) begin
					need = (cur.kind == lcd_seq_pkg::KIND_NIBBLE) ?
						32'(lcd_seq_pkg::WRITES_NIBBLE) : 32'(lcd_seq_pkg::WRITES_BYTE);
					if (acks < lcd_seq_pkg::ACKS_MAX)
						acks++;
					if (acks >= need) begin
						if (cur.delay != 0) begin
							ph = lcd_seq_pkg::PH_WAIT;
							delay_left = 32'(cur.delay);
						end else begin
							ph = lcd_seq_pkg::PH_IDLE;
						end
					end
				end
			end
			lcd_seq_pkg::CMD_TICK: begin
				if (ph == lcd_seq_pkg::PH_WAIT) begin
					if (delay_left > 0)
						delay_left--;
					if (delay_left == 0)
						ph = lcd_seq_pkg::PH_IDLE;
				end
			end
			default: begin
				head = 0;
				tail = 0;
				count = 0;
				ph = lcd_seq_pkg::PH_IDLE;
				cur = '0;
				acks = 0;
				delay_left = 0;
			end
		endcase
		if (ev.cmd != lcd_seq_pkg::CMD_STOP)
			launch_queued();
		idle_now = (ph == lcd_seq_pkg::PH_IDLE && count == 0);
		if (strobe_seq.size() == 0) begin
			pending_writes.push_back('{8'h00, 1'b0, 1'b1, idle_now, dropped});
		end else begin
			foreach (strobe_seq[i])
				pending_writes.push_back('{strobe_seq[i], 1'b1,
					(i == strobe_seq.size() - 1), idle_now, dropped});
		end
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 100)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// compare one output beat against the oldest predicted write
	task check_write(pin_write_t got);
		pin_write_t want;
		if (pending_writes.size() == 0) begin
			report($sformatf("unexpected beat, byte %02h", got.pins));
			return;
		end
		want = pending_writes.pop_front();
		if (got.pins !== want.pins)
			report($sformatf("expander_byte %02h, predicted %02h", got.pins, want.pins));
		if (got.written !== want.written)
			report($sformatf("byte_valid %b, predicted %b", got.written, want.written));
		if (got.last !== want.last)
			report($sformatf("last %b, predicted %b", got.last, want.last));
		if (got.idle !== want.idle)
			report($sformatf("idle %b, predicted %b", got.idle, want.idle));
		if (got.dropped !== want.dropped)
			report($sformatf("push_dropped %b, predicted %b", got.dropped, want.dropped));
	endtask
endclass

module testbench;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         SETTLE_CYCLES  = 20;
	localparam int         PHASE_EVENTS   = 86;
	localparam logic [1:0] KIND_SPARE     = 2'd3;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [lcd_seq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [2:0]                        cfg_wdata;

	lcd_seq_in_if  cmd_if ();
	lcd_seq_out_if res_if ();

	lcd_seq_board board;
	int           quiet_cycles;
	int           stall_left;
	int           useful_events;
	bit           idling;

	lcd_nibble_command_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_if),
		.res_ch    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// output side: check beats, stall in bursts, watch for a hang
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready)
				board.check_write(pin_write_t'{res_if.expander_byte,
					res_if.byte_valid, res_if.last, res_if.idle, res_if.push_dropped});
			if ((res_if.valid && res_if.ready) || (cmd_if.valid && cmd_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic lcd_seq_pkg::in_beat_t beat_of(lcd_seq_pkg::cmd_t c, logic [1:0] kind,
		logic [7:0] value, logic is_data, logic [15:0] delay);
		lcd_seq_pkg::in_beat_t b;
		b.cmd = c;
		b.kind = kind;
		b.value = value;
		b.is_data = is_data;
		b.delay = delay;
		return b;
	endfunction

	// random event; pushes favour real commands with short delays
	function automatic lcd_seq_pkg::in_beat_t rand_event(lcd_seq_pkg::cmd_t c);
		lcd_seq_pkg::in_beat_t b;
		int                    pick;
		b.cmd = c;
		b.kind = 2'($urandom_range(0, 3));
		b.value = 8'($urandom_range(0, 255));
		b.is_data = 1'($urandom_range(0, 1));
		b.delay = 16'($urandom_range(0, 65535));
		if (c == lcd_seq_pkg::CMD_PUSH) begin
			pick = $urandom_range(0, 99);
			b.kind = (pick < 40) ? lcd_seq_pkg::KIND_BYTE :
				(pick < 70) ? lcd_seq_pkg::KIND_NIBBLE :
				(pick < 90) ? lcd_seq_pkg::KIND_DELAY : KIND_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				b.delay = 16'($urandom_range(0, 3));
			else if (pick < 90)
				b.delay = 16'($urandom_range(4, 20));
		end
		return b;
	endfunction

	// drive one event beat and wait for it to be taken
	task automatic send_event(lcd_seq_pkg::in_beat_t b);
		if (idling && $urandom_range(0, 4) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.cmd <= b.cmd;
		cmd_if.cmd_kind <= b.kind;
		cmd_if.value <= b.value;
		cmd_if.is_data <= b.is_data;
		cmd_if.post_delay_ms <= b.delay;
		do @(posedge clk); while (!cmd_if.ready);
		if (!(b.cmd == lcd_seq_pkg::CMD_ACK && board.ph != lcd_seq_pkg::PH_SEND) &&
			!(b.cmd == lcd_seq_pkg::CMD_TICK && board.ph != lcd_seq_pkg::PH_WAIT))
			useful_events++;
		board.note_event(b);
	endtask

	// drain all predicted beats, then give the core time to go quiet
	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (board.pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_masks(logic [2:0] rs, logic [2:0] en);
		cfg_we <= 1'b1;
		cfg_index <= lcd_seq_pkg::CFG_RS_PIN_MASK;
		cfg_wdata <= rs;
		@(posedge clk);
		cfg_index <= lcd_seq_pkg::CFG_EN_PIN_MASK;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.rs_mask = rs;
		board.en_mask = en;
	endtask

	// corner cases: full byte, nibble with spare value bits, delays, stray events, stop
	task automatic directed_events();
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, lcd_seq_pkg::KIND_BYTE, 8'hFF, 1'b1, 16'd0));
		repeat (6)
			send_event(beat_of(lcd_seq_pkg::CMD_ACK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0,
				16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, lcd_seq_pkg::KIND_NIBBLE, 8'hA5, 1'b0,
			16'd2));
		repeat (3)
			send_event(beat_of(lcd_seq_pkg::CMD_ACK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0,
				16'd0));
		repeat (2)
			send_event(beat_of(lcd_seq_pkg::CMD_TICK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0,
				16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_TICK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_ACK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, KIND_SPARE, 8'h5A, 1'b1, 16'hFFFF));
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, lcd_seq_pkg::KIND_BYTE, 8'h00, 1'b0,
			16'hFFFF));
		send_event(beat_of(lcd_seq_pkg::CMD_STOP, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd0));
		send_event(beat_of(lcd_seq_pkg::CMD_PUSH, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd1));
		send_event(beat_of(lcd_seq_pkg::CMD_TICK, lcd_seq_pkg::KIND_DELAY, 8'h00, 1'b0, 16'd0));
	endtask

	// mostly well-formed traffic following the predicted phase, plus noise
	task automatic random_events(int target);
		int goal;
		int pick;
		goal = useful_events + target;
		while (useful_events < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				repeat ($urandom_range(16, 22)) send_event(rand_event(lcd_seq_pkg::CMD_PUSH));
			else if (board.ph == lcd_seq_pkg::PH_WAIT && board.delay_left > 40 && pick < 30)
				send_event(rand_event(lcd_seq_pkg::CMD_STOP));
			else if (board.ph == lcd_seq_pkg::PH_SEND && pick < 60)
				send_event(rand_event(lcd_seq_pkg::CMD_ACK));
			else if (board.ph == lcd_seq_pkg::PH_WAIT && pick < 60)
				send_event(rand_event(lcd_seq_pkg::CMD_TICK));
			else if (pick < 88)
				send_event(rand_event(lcd_seq_pkg::CMD_PUSH));
			else if (pick < 90)
				send_event(rand_event(lcd_seq_pkg::CMD_STOP));
			else
				send_event(rand_event(lcd_seq_pkg::cmd_t'(2'($urandom_range(0, 3)))));
		end
	endtask

	// main sequence
	initial begin
		board = new();
		idling = 1'b1;
		quiet_cycles = 0;
		stall_left = 0;
		useful_events = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lcd_seq_pkg::CFG_RS_PIN_MASK;
		cfg_wdata = 3'd0;
		cmd_if.valid = 1'b0;
		cmd_if.cmd = lcd_seq_pkg::CMD_PUSH;
		cmd_if.cmd_kind = lcd_seq_pkg::KIND_DELAY;
		cmd_if.value = 8'h00;
		cmd_if.is_data = 1'b0;
		cmd_if.post_delay_ms = 16'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		directed_events();
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: write_masks(3'd0, 3'd0);
					2: write_masks(3'd7, 3'd7);
					3: write_masks(3'd2, 3'd1);
					default: write_masks(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
				endcase
			end
			// no idling on either side in the final stretch
			if (p == 4)
				idling = 1'b0;
			random_events(PHASE_EVENTS);
		end
		settle();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== sim.f =====
src/lcd_seq_pkg.sv
src/lcd_seq_if.sv
src/lcd_seq_queue.sv
src/lcd_seq_core.sv
src/lcd_seq_out.sv
src/lcd_nibble_command_sequencer.sv
tb/testbench.sv
